[design/h2b64_pkg.sv]
// ----------------------------------------------------------------------------
// h2b64_pkg
// Shared types, constants and character maps for the hex to base64 stream.
// ----------------------------------------------------------------------------
package h2b64_pkg;

	localparam int GROUP_BITS    = 24;
	localparam int HELD_BITS     = 20;
	localparam int NIBBLE_BITS   = 4;
	localparam int SEXTET_BITS   = 6;
	localparam int COUNT_BITS    = 3;
	localparam int SLOT_BITS     = 2;

	localparam logic [COUNT_BITS-1:0] GROUP_NIBBLES = 3'd6;
	localparam logic [COUNT_BITS-1:0] TWO_BYTES     = 3'd4;
	localparam logic [COUNT_BITS-1:0] ONE_BYTE      = 3'd2;
	localparam logic [COUNT_BITS-1:0] NO_BYTE       = 3'd0;

	localparam logic [SLOT_BITS-1:0] LAST_SLOT = 2'd3;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UPA   = 8'h41;
	localparam logic [7:0] CHAR_UPZ   = 8'h5A;
	localparam logic [7:0] CHAR_LOWA  = 8'h61;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_PAD   = 8'h3D;
	localparam logic [7:0] LETTER_OFS = 8'd10;

	// one gathered group on its way to the serializer
	typedef struct packed {
		logic [GROUP_BITS-1:0] bits;   // left aligned, unused low bits zero
		logic [1:0]            pad;    // number of '=' characters at the end
		logic                  last;   // final group of the stream
	} group_t;

	function automatic logic [NIBBLE_BITS-1:0] nibble_of(input logic [7:0] c);
		logic [7:0] v;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			v = c - CHAR_ZERO;
		end else if (c >= CHAR_UPA && c <= CHAR_UPZ) begin
			v = c - CHAR_UPA + LETTER_OFS;
		end else begin
			v = c - CHAR_LOWA + LETTER_OFS;
		end
		return v[NIBBLE_BITS-1:0];
	endfunction

	function automatic logic [7:0] b64_of(input logic [SEXTET_BITS-1:0] s);
		logic [7:0] v;
		v = {2'b00, s};
		if (v < 8'd26) begin
			return CHAR_UPA + v;
		end else if (v < 8'd52) begin
			return CHAR_LOWA + v - 8'd26;
		end else if (v < 8'd62) begin
			return CHAR_ZERO + v - 8'd52;
		end else if (v == 8'd62) begin
			return CHAR_PLUS;
		end else begin
			return CHAR_SLASH;
		end
	endfunction

endpackage

[design/hex_to_base64_stream.sv]
// ----------------------------------------------------------------------------
// hex_to_base64_stream
// Streaming converter from ASCII hex characters to base64 characters.
// ----------------------------------------------------------------------------
// The input side takes one hex character per cycle. Every six characters
// (three bytes) become four base64 characters; at end of text a lone nibble
// is dropped and a partial group of one or two bytes is flushed with '='
// padding, with tlast on the final character. An end of text that leaves no
// whole byte gives no output. The serializer emits one character per cycle
// while the output side is ready; a group passes through the queue, the
// group register and the output register before its first character
// appears. Groups wait in a QUEUE_DEPTH entry queue, and input stalls only
// when that queue is full, which happens when ends of text arrive more often
// than once per four input characters or when the output side backs up.
// ----------------------------------------------------------------------------
module hex_to_base64_stream import h2b64_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] hex_char
	input  logic       s_axis_tlast,   // end_of_text
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] b64_char
	output logic       m_axis_tlast    // last_char
);

	logic   q_full;
	logic   q_empty;
	logic   push;
	logic   pop;
	group_t push_group;
	group_t head;

	h2b64_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_char    (s_axis_tdata),
		.in_end     (s_axis_tlast),
		.q_full     (q_full),
		.push       (push),
		.push_group (push_group)
	);

	h2b64_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.full       (q_full),
		.pop        (pop),
		.empty      (q_empty),
		.head       (head)
	);

	h2b64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

[design/h2b64_front.sv]
// ----------------------------------------------------------------------------
// h2b64_front
// Decodes hex characters, gathers nibbles into groups and queues each group.
// ----------------------------------------------------------------------------
module h2b64_front import h2b64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_end,
	input  logic       q_full,
	output logic       push,
	output group_t     push_group
);

	logic [HELD_BITS-1:0]  group_q;
	logic [COUNT_BITS-1:0] count_q;

	logic                  accept;
	logic [GROUP_BITS-1:0] new_bits;
	logic [GROUP_BITS-1:0] even_bits;
	logic [COUNT_BITS-1:0] cnt_next;
	logic [COUNT_BITS-1:0] even_cnt;
	logic                  full_grp;

	assign in_ready  = !q_full;
	assign accept    = in_valid && !q_full;
	assign new_bits  = {group_q, nibble_of(in_char)};
	assign cnt_next  = count_q + 3'd1;
	assign full_grp  = (cnt_next == GROUP_NIBBLES);
	// a lone trailing nibble is dropped at end of text
	assign even_bits = cnt_next[0] ? {{NIBBLE_BITS{1'b0}}, group_q} : new_bits;
	assign even_cnt  = {cnt_next[COUNT_BITS-1:1], 1'b0};

	always_comb begin
		push_group.bits = new_bits;
		push_group.pad  = 2'd0;
		push_group.last = 1'b0;
		push            = 1'b0;
		if (in_end) begin
			push_group.last = 1'b1;
			push            = accept && (even_cnt != NO_BYTE);
			case (even_cnt)
				TWO_BYTES: begin
					push_group.bits = even_bits << 8;
					push_group.pad  = 2'd1;
				end
				ONE_BYTE: begin
					push_group.bits = even_bits << 16;
					push_group.pad  = 2'd2;
				end
				default: begin
					push_group.bits = even_bits;
					push_group.pad  = 2'd0;
				end
			endcase
		end else begin
			push = accept && full_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (in_end || full_grp) begin
				group_q <= '0;
				count_q <= '0;
			end else begin
				group_q <= new_bits[HELD_BITS-1:0];
				count_q <= cnt_next;
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < GROUP_NIBBLES)
		else $error("nibble count out of range");

endmodule

[design/h2b64_fifo.sv]
// ----------------------------------------------------------------------------
// h2b64_fifo
// Short queue of gathered groups between the front and the serializer.
// ----------------------------------------------------------------------------
module h2b64_fifo import h2b64_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  group_t push_group,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output group_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_DEPTH = CW'(DEPTH);

	group_t         mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  count_q;

	assign full  = (count_q == CNT_DEPTH);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_DEPTH)
		else $error("queue count beyond depth");

endmodule

[design/h2b64_back.sv]
// ----------------------------------------------------------------------------
// h2b64_back
// Serializes each queued group into four base64 chars, one per cycle if ready.
// ----------------------------------------------------------------------------
module h2b64_back import h2b64_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  group_t     q_head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       out_last
);

	group_t               cur_q;
	logic                 cur_valid_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic                 out_valid_q;
	logic [7:0]           out_char_q;
	logic                 out_last_q;

	logic                   advance;
	logic                   slot_done;
	logic [SEXTET_BITS-1:0] sextet;
	logic [7:0]             ch;

	assign advance   = cur_valid_q && (!out_valid_q || out_ready);
	assign slot_done = advance && (slot_q == LAST_SLOT);
	assign pop       = !q_empty && (!cur_valid_q || slot_done);

	always_comb begin
		case (slot_q)
			2'd0:    sextet = cur_q.bits[23:18];
			2'd1:    sextet = cur_q.bits[17:12];
			2'd2:    sextet = cur_q.bits[11:6];
			default: sextet = cur_q.bits[5:0];
		endcase
		if ({1'b0, slot_q} >= 3'd4 - {1'b0, cur_q.pad}) begin
			ch = CHAR_PAD;
		end else begin
			ch = b64_of(sextet);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
		end
		if (advance) begin
			out_char_q <= ch;
			out_last_q <= cur_q.last && (slot_q == LAST_SLOT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
			end else if (slot_done) begin
				cur_valid_q <= 1'b0;
			end
			if (advance) begin
				slot_q <= slot_q + SLOT_BITS'(1);
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	a_pad_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q && (cur_q.pad != 2'd0) |-> cur_q.last)
		else $error("padding on a group that is not final");
	a_load_on_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (slot_q == '0) || slot_done)
		else $error("group loaded mid sequence");

endmodule
